// ===== rtl/tmd_pkg.sv =====
// shared types and constants for the tempo map duration block
`default_nettype none
package tmd_pkg;
	localparam int TABLE_DEPTH_DEF = 128;
	localparam int TIME_FRAC_BITS_DEF = 16;
	localparam int TIME_W = 32;
	localparam int TEMPO_W = 16;
	localparam int OUT_W = 48;
	localparam int LEN_W = 8;
	localparam int IDX_IN_W = 7;
	localparam int STATUS_W = 3;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_TABLE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PAST_END = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_TOTAL = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ZERO_TEMPO = 3'd4;

	localparam logic REG_TABLE_LENGTH = 1'b0;
	localparam logic REG_TOTAL_DURATION = 1'b1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_PIECE, S_IDIV, S_READ, S_TEMPO, S_TDIV, S_ACC, S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic load_wr;
		logic setup;
		logic piece_start;
		logic idiv_start;
		logic idiv_step;
		logic read_req;
		logic tdiv_start;
		logic tdiv_step;
		logic accumulate;
		logic set_err;
		logic set_zero;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_load;
		logic err;
		logic span_done;
		logic idiv_done;
		logic tempo_zero;
		logic tdiv_done;
	} stat_t;
endpackage
`default_nettype wire

// ===== rtl/tmd_if.sv =====
// valid ready channel interfaces
`default_nettype none
interface tmd_in_if (input wire logic clk);
	logic valid;
	logic ready;
	logic operation;
	logic [tmd_pkg::IDX_IN_W-1:0] entry_index;
	logic [tmd_pkg::TEMPO_W-1:0] entry_tempo;
	logic [tmd_pkg::TIME_W-1:0] start_time;
	logic [tmd_pkg::TIME_W-1:0] span_length;
	modport source (output valid, operation, entry_index, entry_tempo, start_time,
		span_length, input ready);
	modport sink (input valid, operation, entry_index, entry_tempo, start_time,
		span_length, output ready);
endinterface

interface tmd_out_if (input wire logic clk);
	logic valid;
	logic ready;
	logic [tmd_pkg::OUT_W-1:0] scaled_duration;
	logic [tmd_pkg::STATUS_W-1:0] status;
	modport source (output valid, scaled_duration, status, input ready);
	modport sink (input valid, scaled_duration, status, output ready);
endinterface

interface tmd_cfg_if (input wire logic clk);
	logic valid;
	logic ready;
	logic index;
	logic [tmd_pkg::TIME_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tmd_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module tmd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input wire logic clk,
	input wire logic we,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write or registered read
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		if (re) rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/tmd_ctrl.sv =====
// sequencer for load and query items
`default_nettype none
module tmd_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic out_busy,
	input tmd_pkg::stat_t st,
	output tmd_pkg::cmd_t cmd
);
	tmd_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tmd_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tmd_pkg::S_IDLE: if (in_valid) state_d = tmd_pkg::S_CHECK;
			tmd_pkg::S_CHECK: begin
				if (st.is_load || st.err) state_d = tmd_pkg::S_DONE;
				else state_d = tmd_pkg::S_PIECE;
			end
			tmd_pkg::S_PIECE: begin
				if (st.span_done) state_d = tmd_pkg::S_DONE;
				else state_d = tmd_pkg::S_IDIV;
			end
			tmd_pkg::S_IDIV: if (st.idiv_done) state_d = tmd_pkg::S_READ;
			tmd_pkg::S_READ: state_d = tmd_pkg::S_TEMPO;
			tmd_pkg::S_TEMPO: begin
				if (st.tempo_zero) state_d = tmd_pkg::S_DONE;
				else state_d = tmd_pkg::S_TDIV;
			end
			tmd_pkg::S_TDIV: if (st.tdiv_done) state_d = tmd_pkg::S_ACC;
			tmd_pkg::S_ACC: state_d = tmd_pkg::S_PIECE;
			tmd_pkg::S_DONE: if (!out_busy) state_d = tmd_pkg::S_IDLE;
			default: state_d = tmd_pkg::S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			tmd_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.capture = in_valid;
			end
			tmd_pkg::S_CHECK: begin
				cmd.load_wr = st.is_load;
				cmd.set_err = st.err && !st.is_load;
				cmd.setup = 1'b1;
			end
			tmd_pkg::S_PIECE: begin
				cmd.piece_start = !st.span_done;
				cmd.idiv_start = !st.span_done;
			end
			tmd_pkg::S_IDIV: cmd.idiv_step = 1'b1;
			tmd_pkg::S_READ: cmd.read_req = 1'b1;
			tmd_pkg::S_TEMPO: begin
				cmd.set_zero = st.tempo_zero;
				cmd.tdiv_start = !st.tempo_zero;
			end
			tmd_pkg::S_TDIV: cmd.tdiv_step = 1'b1;
			tmd_pkg::S_ACC: cmd.accumulate = 1'b1;
			tmd_pkg::S_DONE: cmd.out_load = !out_busy;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/tmd_dp.sv =====
// datapath: table, index and piece dividers, saturating sum
`default_nettype none
module tmd_dp #(
	parameter int TABLE_DEPTH = tmd_pkg::TABLE_DEPTH_DEF,
	parameter int TIME_FRAC_BITS = tmd_pkg::TIME_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input tmd_pkg::cmd_t cmd,
	output tmd_pkg::stat_t st,
	input wire logic in_operation,
	input wire logic [tmd_pkg::IDX_IN_W-1:0] in_entry_index,
	input wire logic [tmd_pkg::TEMPO_W-1:0] in_entry_tempo,
	input wire logic [tmd_pkg::TIME_W-1:0] in_start_time,
	input wire logic [tmd_pkg::TIME_W-1:0] in_span_length,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [tmd_pkg::TIME_W-1:0] cfg_data,
	output logic [tmd_pkg::OUT_W-1:0] res_dur,
	output logic [tmd_pkg::STATUS_W-1:0] res_status
);
	localparam int TW = tmd_pkg::TIME_W;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int LW = tmd_pkg::LEN_W;
	localparam int PW = TW + CW;            // x * len
	localparam int QW = PW;
	localparam int NW = TW + 14;            // piece * 15360
	localparam int OW = tmd_pkg::OUT_W;
	localparam int TPW = tmd_pkg::TEMPO_W;
	localparam logic [OW-1:0] OUT_MAX = {OW{1'b1}};
	localparam logic [TW-1:0] ONE = TW'(1) << TIME_FRAC_BITS;
	localparam logic [13:0] SCALE = 14'd15360;

	// configuration registers
	logic [LW-1:0] tlen_q;
	logic [TW-1:0] total_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q <= '0;
			total_q <= TW'(65536);
		end else if (cfg_we) begin
			if (cfg_index == tmd_pkg::REG_TABLE_LENGTH) tlen_q <= cfg_data[LW-1:0];
			else total_q <= cfg_data;
		end
	end

	// captured item
	logic op_q;
	logic [tmd_pkg::IDX_IN_W-1:0] eidx_q;
	logic [TPW-1:0] etempo_q;
	logic [TW-1:0] x_q, end_q, span_q, ub_q;
	logic [CW-1:0] len_q;
	logic [OW-1:0] sum_q;
	logic [tmd_pkg::STATUS_W-1:0] stat_q;

	logic [CW-1:0] len_c;
	always_comb begin
		if (32'(tlen_q) > 32'(TABLE_DEPTH)) len_c = CW'(TABLE_DEPTH);
		else len_c = CW'(tlen_q);
	end

	logic [TW:0] end_w;
	assign end_w = {1'b0, x_q} + {1'b0, span_q};

	logic [TW:0] ub_w;
	assign ub_w = {1'b0, x_q & ~(ONE - TW'(1))} + {1'b0, ONE};

	// index divider: (x*len)/total, restoring
	logic [PW-1:0] inum_q;
	logic [TW:0] irem_q;
	logic [$clog2(PW+1)-1:0] icnt_q;
	logic [TW:0] irem_sh;
	assign irem_sh = {irem_q[TW-1:0], inum_q[PW-1]};

	// piece divider: piece*15360/tempo
	logic [NW-1:0] tnum_q;
	logic [TPW:0] trem_q;
	logic [$clog2(NW+1)-1:0] tcnt_q;
	logic [TPW-1:0] tf_q;
	logic [TPW:0] trem_sh;
	assign trem_sh = {trem_q[TPW-1:0], tnum_q[NW-1]};

	logic [TPW-1:0] rdata;
	logic [AW-1:0] ram_addr;
	logic [QW-1:0] idx_clamp;
	always_comb begin
		if (inum_q >= QW'(len_q)) idx_clamp = QW'(len_q - CW'(1));
		else idx_clamp = inum_q;
	end
	assign ram_addr = cmd.load_wr ? AW'(eidx_q) : idx_clamp[AW-1:0];

	logic wr_ok;
	assign wr_ok = cmd.load_wr && (32'(eidx_q) < 32'(TABLE_DEPTH));

	tmd_ram #(.WIDTH(TPW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(wr_ok), .re(cmd.read_req), .addr(ram_addr),
		.wdata(etempo_q), .rdata(rdata)
	);

	logic [OW:0] sum_w;
	assign sum_w = {1'b0, sum_q} + {1'b0, OW'(tnum_q)};

	// sequencing registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_operation;
			eidx_q <= in_entry_index;
			etempo_q <= in_entry_tempo;
			x_q <= in_start_time;
			span_q <= in_span_length;
		end
		if (cmd.setup) begin
			len_q <= len_c;
			end_q <= end_w[TW] ? {TW{1'b1}} : end_w[TW-1:0];
			sum_q <= '0;
			if (cmd.set_err) begin
				if (len_c == '0) stat_q <= tmd_pkg::ST_NO_TABLE;
				else stat_q <= tmd_pkg::ST_PAST_END;
			end else begin
				stat_q <= tmd_pkg::ST_OK;
			end
		end
		if (cmd.piece_start) begin
			ub_q <= (ub_w > {1'b0, end_q}) ? end_q : ub_w[TW-1:0];
		end
		if (cmd.idiv_start) begin
			inum_q <= PW'(x_q) * PW'(len_q);
			irem_q <= '0;
			icnt_q <= '0;
		end else if (cmd.idiv_step && !st.idiv_done) begin
			if (irem_sh >= {1'b0, total_q}) begin
				irem_q <= irem_sh - {1'b0, total_q};
				inum_q <= {inum_q[PW-2:0], 1'b1};
			end else begin
				irem_q <= irem_sh;
				inum_q <= {inum_q[PW-2:0], 1'b0};
			end
			icnt_q <= icnt_q + 1'b1;
		end
		if (cmd.read_req) tf_q <= '0;
		if (cmd.set_zero) begin
			sum_q <= OUT_MAX;
			stat_q <= tmd_pkg::ST_ZERO_TEMPO;
		end
		if (cmd.tdiv_start) begin
			tf_q <= rdata;
			tnum_q <= NW'(ub_q - x_q) * NW'(SCALE);
			trem_q <= '0;
			tcnt_q <= '0;
		end else if (cmd.tdiv_step && !st.tdiv_done) begin
			if (trem_sh >= {1'b0, tf_q}) begin
				trem_q <= trem_sh - {1'b0, tf_q};
				tnum_q <= {tnum_q[NW-2:0], 1'b1};
			end else begin
				trem_q <= trem_sh;
				tnum_q <= {tnum_q[NW-2:0], 1'b0};
			end
			tcnt_q <= tcnt_q + 1'b1;
		end
		if (cmd.accumulate) begin
			sum_q <= sum_w[OW] ? OUT_MAX : sum_w[OW-1:0];
			x_q <= ub_q;
		end
	end

	assign res_dur = (stat_q == tmd_pkg::ST_NO_TABLE || stat_q == tmd_pkg::ST_PAST_END)
		? '0 : sum_q;
	assign res_status = stat_q;

	// status to controller
	always_comb begin
		st.is_load = (op_q == tmd_pkg::OP_LOAD);
		st.err = (len_c == '0) || (x_q >= total_q);
		st.span_done = (x_q >= end_q);
		st.idiv_done = (32'(icnt_q) == 32'(PW));
		st.tempo_zero = (rdata == '0);
		st.tdiv_done = (32'(tcnt_q) == 32'(NW));
	end
endmodule
`default_nettype wire

// ===== rtl/tempo_map_duration.sv =====
// top level of the tempo map duration block
// Channels: in (load or query words), out (one result word per input word),
// cfg (register writes, index 0 table_length, index 1 total_duration).
// A load word writes one table entry; its result (zero, status ok) then goes
// to the output register. A query walks the span one whole-second piece at a
// time; each piece takes a 40-step index division (x*len/total, one quotient
// bit a cycle) and a 46-step division of piece*15360 by the tempo, and the
// result is loaded once the last piece is summed. The next word is taken only
// after the result of the last one is loaded into the output register.
// One word is in work at a time; in.ready is high only while the block is idle.
// The result is held in an output register until out.ready takes it; while
// it waits one more word can be taken, but its result stays back until the
// register is free, so a stalled receiver stalls the input after that word.
// Reset sets table_length to 0 and total_duration to 1.0 second; table
// contents stay undefined until written, no clearing pass is run.
// cfg.ready is always high; write only while idle.
`default_nettype none
module tempo_map_duration #(
	parameter int TABLE_DEPTH = tmd_pkg::TABLE_DEPTH_DEF,
	parameter int TIME_FRAC_BITS = tmd_pkg::TIME_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	tmd_in_if.sink in_ch,
	tmd_out_if.source out_ch,
	tmd_cfg_if.sink cfg
);
	tmd_pkg::cmd_t cmd;
	tmd_pkg::stat_t st;
	logic in_ready;
	logic [tmd_pkg::OUT_W-1:0] res_dur;
	logic [tmd_pkg::STATUS_W-1:0] res_status;
	logic out_valid_q;
	logic [tmd_pkg::OUT_W-1:0] out_dur_q;
	logic [tmd_pkg::STATUS_W-1:0] out_status_q;

	assign in_ch.ready = in_ready;
	assign cfg.ready = 1'b1;

	tmd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ready),
		.out_busy(out_valid_q), .st(st), .cmd(cmd)
	);

	tmd_dp #(.TABLE_DEPTH(TABLE_DEPTH), .TIME_FRAC_BITS(TIME_FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .st(st),
		.in_operation(in_ch.operation), .in_entry_index(in_ch.entry_index),
		.in_entry_tempo(in_ch.entry_tempo), .in_start_time(in_ch.start_time),
		.in_span_length(in_ch.span_length),
		.cfg_we(cfg.valid), .cfg_index(cfg.index), .cfg_data(cfg.data),
		.res_dur(res_dur), .res_status(res_status)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_dur_q <= res_dur;
			out_status_q <= res_status;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.scaled_duration = out_dur_q;
	assign out_ch.status = out_status_q;
endmodule
`default_nettype wire

// ===== rtl/tmd_checker.sv =====
// port level checks for the tempo map duration block
`default_nettype none
module tmd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [tmd_pkg::OUT_W-1:0] out_dur,
	input wire logic [tmd_pkg::STATUS_W-1:0] out_status
);
	// ready is low in the cycle after an input word is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");
	// stalled result keeps its status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_status)) else $error("status changed");
	// status codes stay in range
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status <= tmd_pkg::ST_ZERO_TEMPO) else $error("bad status");
	// error results carry zero duration
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == tmd_pkg::ST_NO_TABLE ||
		out_status == tmd_pkg::ST_PAST_END) |-> out_dur == '0)
		else $error("nonzero duration on error");
	// stalled result holds
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_dur))
		else $error("result dropped");
endmodule

bind tempo_map_duration tmd_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_dur(out_ch.scaled_duration), .out_status(out_ch.status)
);
`default_nettype wire
